/* src/leq_pkg.sv */
package leq_pkg;

  localparam int unsigned QueueDepth  = 16;
  localparam int unsigned IdxW        = $clog2(QueueDepth);
  localparam int unsigned CntW        = $clog2(QueueDepth + 1);
  localparam int unsigned PayloadBits = 32;
  localparam int unsigned TypeW       = 5;
  localparam int unsigned NumTypes    = 22;
  localparam int unsigned CountW      = 32;

  localparam logic [TypeW-1:0]    ErrorType     = TypeW'(21);
  localparam logic [NumTypes-1:0] DroppableRst  = NumTypes'(6144);

  typedef enum logic [1:0] {
    CFG_QUEUE_LIMIT = 2'd0,
    CFG_SUBSCRIBED  = 2'd1,
    CFG_DROPPABLE   = 2'd2,
    CFG_UNUSED      = 2'd3
  } cfg_index_e;

  typedef enum logic [2:0] {
    OUT_QUEUED       = 3'd0,
    OUT_EVICT_DROP   = 3'd1,
    OUT_REJECTED     = 3'd2,
    OUT_EVICT_OLDEST = 3'd3,
    OUT_FILTERED     = 3'd4
  } outcome_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUB,
    ST_POP,
    ST_SCAN,
    ST_SHIFT,
    ST_APPEND,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic                   operation;
    logic [TypeW-1:0]       event_type;
    logic [PayloadBits-1:0] event_payload;
  } evt_t;

  typedef struct packed {
    logic [2:0]             publish_outcome;
    logic                   out_valid;
    logic [TypeW-1:0]       out_type;
    logic [PayloadBits-1:0] out_payload;
    logic [CountW-1:0]      dropped_count_total;
    logic [CntW-1:0]        queue_fill;
  } res_t;

  typedef struct packed {
    logic [TypeW-1:0]       etype;
    logic [PayloadBits-1:0] payload;
  } entry_t;

  function automatic logic type_in(logic [NumTypes-1:0] mask, logic [TypeW-1:0] t);
    logic hit;
    hit = 1'b0;
    if (32'(t) < NumTypes) begin
      hit = mask[t];
    end
    return hit;
  endfunction

endpackage

/* src/lossy_event_queue_core.sv */
// Channel   Direction  Handshake                  Beat
// evt       in         evt_valid_i / evt_stall_o  leq_pkg::evt_t (publish or pop)
// res       out        res_valid_o / res_stall_i  leq_pkg::res_t (one per input beat)
// cfg       in         cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A publish is filtered or appended; when the queue is at its limit it first scans for the
// oldest droppable entry one entry per cycle and, unless it rejects the new event, shifts
// the tail down one entry per cycle. A pop reads the head, shifts the tail down and may
// then queue the error event. The single read port of the entry store sets this pace.
// Reset clears the fill and the loss counters and restores the register defaults; the
// entry store is not cleared. A stalled result holds back only the next beat's final write.
module lossy_event_queue_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,

  input  logic                       evt_valid_i,
  output logic                       evt_stall_o,
  input  leq_pkg::evt_t              evt_i,

  output logic                       res_valid_o,
  input  logic                       res_stall_i,
  output leq_pkg::res_t              res_o,

  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [leq_pkg::NumTypes-1:0] cfg_data_i
);

  localparam int unsigned IdxW  = leq_pkg::IdxW;
  localparam int unsigned CntW  = leq_pkg::CntW;
  localparam int unsigned TypeW = leq_pkg::TypeW;
  localparam int unsigned PayW  = leq_pkg::PayloadBits;
  localparam int unsigned CW    = leq_pkg::CountW;
  localparam int unsigned NT    = leq_pkg::NumTypes;
  localparam logic [CntW-1:0] DepthCnt = CntW'(leq_pkg::QueueDepth);

  // Configuration registers.
  logic [4:0]    limit_q;
  logic [NT-1:0] sub_q, drop_q;

  // Entry store: flip-flops, one shared read mux, no reset.
  leq_pkg::entry_t store_q [leq_pkg::QueueDepth];
  logic            wr_en;
  logic [IdxW-1:0] wr_idx, rd_idx;
  leq_pkg::entry_t wr_data, rd_data;

  leq_pkg::state_e   state_q, state_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [CntW-1:0]   idx_q, idx_d;
  logic [CW-1:0]     total_q, total_d, pend_q, pend_d;
  logic              op_q, op_d;
  logic [TypeW-1:0]  type_q, type_d;
  logic [PayW-1:0]   pay_q, pay_d;
  leq_pkg::outcome_e outcome_q, outcome_d;
  logic              popv_q, popv_d;
  logic [TypeW-1:0]  ptype_q, ptype_d;
  logic [PayW-1:0]   ppay_q, ppay_d;
  logic              res_valid_q, res_valid_d;
  leq_pkg::res_t     res_q, res_d;

  logic [CntW-1:0] limit_eff;
  logic [CntW-1:0] idx_inc;
  logic            in_accept;
  logic            slot_free;

  assign limit_eff = (limit_q == 5'd0 || CntW'(limit_q) > DepthCnt) ? DepthCnt
                                                                    : CntW'(limit_q);
  assign idx_inc   = idx_q + CntW'(1);
  assign rd_data   = store_q[rd_idx];
  assign in_accept = evt_valid_i && !evt_stall_o;
  assign slot_free = !res_valid_q || !res_stall_i;

  assign evt_stall_o = (state_q != leq_pkg::ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= 5'd0;
      sub_q   <= '0;
      drop_q  <= leq_pkg::DroppableRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (leq_pkg::cfg_index_e'(cfg_index_i))
        leq_pkg::CFG_QUEUE_LIMIT: limit_q <= cfg_data_i[4:0];
        leq_pkg::CFG_SUBSCRIBED:  sub_q   <= cfg_data_i;
        leq_pkg::CFG_DROPPABLE:   drop_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= leq_pkg::ST_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      total_q     <= '0;
      pend_q      <= '0;
      op_q        <= 1'b0;
      outcome_q   <= leq_pkg::OUT_QUEUED;
      popv_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      total_q     <= total_d;
      pend_q      <= pend_d;
      op_q        <= op_d;
      outcome_q   <= outcome_d;
      popv_q      <= popv_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q  <= type_d;
    pay_q   <= pay_d;
    ptype_q <= ptype_d;
    ppay_q  <= ppay_d;
    res_q   <= res_d;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    total_d     = total_q;
    pend_d      = pend_q;
    op_d        = op_q;
    type_d      = type_q;
    pay_d       = pay_q;
    outcome_d   = outcome_q;
    popv_d      = popv_q;
    ptype_d     = ptype_q;
    ppay_d      = ppay_q;
    res_valid_d = res_valid_q && res_stall_i;
    res_d       = res_q;
    wr_en       = 1'b0;
    wr_idx      = idx_q[IdxW-1:0];
    wr_data     = rd_data;
    rd_idx      = idx_q[IdxW-1:0];

    unique case (state_q)
      leq_pkg::ST_IDLE: begin
        if (in_accept) begin
          op_d      = evt_i.operation;
          type_d    = evt_i.event_type;
          pay_d     = evt_i.event_payload;
          outcome_d = leq_pkg::OUT_QUEUED;
          popv_d    = 1'b0;
          ptype_d   = '0;
          ppay_d    = '0;
          state_d   = evt_i.operation ? leq_pkg::ST_POP : leq_pkg::ST_PUB;
        end
      end

      leq_pkg::ST_PUB: begin
        idx_d = '0;
        if (!leq_pkg::type_in(sub_q, type_q)) begin
          outcome_d = leq_pkg::OUT_FILTERED;
          state_d   = leq_pkg::ST_FINISH;
        end else if (cnt_q >= limit_eff) begin
          state_d = leq_pkg::ST_SCAN;
        end else begin
          state_d = leq_pkg::ST_APPEND;
        end
      end

      leq_pkg::ST_SCAN: begin
        // Look for the oldest droppable entry, one entry per cycle.
        if (idx_q == cnt_q) begin
          if (leq_pkg::type_in(drop_q, type_q)) begin
            outcome_d = leq_pkg::OUT_REJECTED;
            if (total_q != '1) total_d = total_q + CW'(1);
            if (pend_q != '1)  pend_d  = pend_q + CW'(1);
            state_d = leq_pkg::ST_FINISH;
          end else begin
            outcome_d = leq_pkg::OUT_EVICT_OLDEST;
            idx_d     = '0;
            state_d   = leq_pkg::ST_SHIFT;
          end
        end else if (leq_pkg::type_in(drop_q, rd_data.etype)) begin
          outcome_d = leq_pkg::OUT_EVICT_DROP;
          state_d   = leq_pkg::ST_SHIFT;
        end else begin
          idx_d = idx_inc;
        end
      end

      leq_pkg::ST_POP: begin
        rd_idx = '0;
        idx_d  = '0;
        if (cnt_q == '0) begin
          state_d = leq_pkg::ST_FINISH;
        end else begin
          popv_d  = 1'b1;
          ptype_d = rd_data.etype;
          ppay_d  = rd_data.payload;
          state_d = leq_pkg::ST_SHIFT;
        end
      end

      leq_pkg::ST_SHIFT: begin
        // Close the gap at idx_q by moving the tail down one entry per cycle.
        rd_idx = idx_inc[IdxW-1:0];
        if (idx_inc < cnt_q) begin
          wr_en   = 1'b1;
          wr_idx  = idx_q[IdxW-1:0];
          wr_data = rd_data;
          idx_d   = idx_inc;
        end else begin
          cnt_d = cnt_q - CntW'(1);
          if (op_q && !popv_q) begin
            state_d = leq_pkg::ST_FINISH;
          end else if (op_q) begin
            // A pop that empties the queue reports pending losses as an error event.
            if (cnt_q == CntW'(1) && pend_q != '0) begin
              type_d  = leq_pkg::ErrorType;
              pay_d   = PayW'(pend_q);
              pend_d  = '0;
              state_d = leq_pkg::ST_PUB;
            end else begin
              state_d = leq_pkg::ST_FINISH;
            end
          end else begin
            if (total_q != '1) total_d = total_q + CW'(1);
            if (pend_q != '1)  pend_d  = pend_q + CW'(1);
            state_d = leq_pkg::ST_APPEND;
          end
          popv_d = popv_q && op_q;
        end
      end

      leq_pkg::ST_APPEND: begin
        wr_en   = 1'b1;
        wr_idx  = cnt_q[IdxW-1:0];
        wr_data = '{etype: type_q, payload: pay_q};
        cnt_d   = cnt_q + CntW'(1);
        state_d = leq_pkg::ST_FINISH;
      end

      leq_pkg::ST_FINISH: begin
        if (slot_free) begin
          res_valid_d               = 1'b1;
          res_d.publish_outcome     = op_q ? 3'(leq_pkg::OUT_QUEUED) : 3'(outcome_q);
          res_d.out_valid           = popv_q;
          res_d.out_type            = ptype_q;
          res_d.out_payload         = ppay_q;
          res_d.dropped_count_total = total_q;
          res_d.queue_fill          = cnt_q;
          state_d                   = leq_pkg::ST_IDLE;
        end
      end

      default: state_d = leq_pkg::ST_IDLE;
    endcase
  end

  // The fill never exceeds the physical depth.
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= DepthCnt)
    else $error("queue fill above depth");

  // An accepted beat always starts a multi-cycle operation.
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> state_q != leq_pkg::ST_IDLE)
    else $error("sequencer idle after accepting a beat");

  // The shifter only runs on a non-empty queue.
  a_shift_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == leq_pkg::ST_SHIFT |-> cnt_q != '0)
    else $error("shift on empty queue");

  // The loss total never decreases.
  a_total_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> total_q >= $past(total_q))
    else $error("loss total decreased");

endmodule
